>>> rtl/bbs_pkg.sv
`default_nettype none

package bbs_pkg;

    localparam int LEVEL_W = 8;
    localparam int COUNT_W = 8;
    localparam int TIMER_W = 8;
    localparam int CFG_INDEX_W = 4;

    localparam logic [LEVEL_W-1:0] SILENCE = 8'h00;
    localparam logic [TIMER_W-1:0] BEEP_LENGTH_RST = 8'd50;
    localparam logic [TIMER_W-1:0] GAP_LENGTH_RST = 8'd50;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_BEEP_LENGTH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_LENGTH = 4'd1;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_BEEPING = 3'b010,
        MODE_GAP     = 3'b100
    } mode_t;

endpackage

`default_nettype wire

>>> rtl/beep_burst_sequencer_top.sv
`default_nettype none
// The result of an input transfer is registered and shows on the m_ side in the next cycle.
// Throughput: one item per cycle; a new item is taken whenever the result
// register is empty or its result is taken in the same cycle.
// Reset (aresetn low at a clock edge): idle, timer, beep count, volume and
// drive level cleared, no result pending, both lengths back to 50 ticks.
module beep_burst_sequencer_top (
    input  wire                          aclk,
    input  wire                          aresetn,
    // item channel
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_cmd,
    input  wire  [bbs_pkg::COUNT_W-1:0]  s_beep_count,
    input  wire  [bbs_pkg::LEVEL_W-1:0]  s_volume,
    // result channel
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [bbs_pkg::LEVEL_W-1:0]  m_drive_level,
    output logic                         m_busy_res,
    // register write channel
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [bbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire  [bbs_pkg::TIMER_W-1:0]  cfg_data
);
    import bbs_pkg::*;

    // Configuration registers
    logic [TIMER_W-1:0] beep_length_reg;
    logic [TIMER_W-1:0] gap_length_reg;

    // Sequencer state; the drive level and busy flag double as the result
    // payload, since state only moves on a transfer into a free result slot.
    mode_t              mode_reg,        mode_next;
    logic [TIMER_W-1:0] tick_timer_reg,  tick_timer_next;
    logic [COUNT_W-1:0] beeps_left_reg,  beeps_left_next;
    logic [LEVEL_W-1:0] held_volume_reg, held_volume_next;
    logic [LEVEL_W-1:0] level_reg,       level_next;
    logic               m_valid_reg;

    logic               s_accept;
    logic [TIMER_W-1:0] timer_dec;

    // Take a new item when the result slot is empty or drains this cycle.
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign m_valid       = m_valid_reg;
    assign m_drive_level = level_reg;
    assign m_busy_res    = (mode_reg != MODE_IDLE);

    // Timer counts down before the zero test, so a loaded 0 lasts 256 ticks.
    assign timer_dec = tick_timer_reg - TIMER_W'(1);

    always_comb begin
        mode_next        = mode_reg;
        tick_timer_next  = tick_timer_reg;
        beeps_left_next  = beeps_left_reg;
        held_volume_next = held_volume_reg;
        level_next       = level_reg;

        if (s_cmd == CMD_REQUEST) begin
            // Zero count: drop the request. Zero volume: load the count only.
            if (s_beep_count != '0) begin
                beeps_left_next = s_beep_count;
                if (s_volume != '0) begin
                    // Start a beep at once, whatever the current mode.
                    held_volume_next = s_volume;
                    beeps_left_next  = s_beep_count - COUNT_W'(1);
                    mode_next        = MODE_BEEPING;
                    tick_timer_next  = beep_length_reg;
                    level_next       = s_volume;
                end
            end
        end else begin
            case (mode_reg)
                MODE_BEEPING: begin
                    tick_timer_next = timer_dec;
                    if (timer_dec == '0) begin
                        // Beep over: silence, then idle or gap.
                        level_next = SILENCE;
                        if (beeps_left_reg == '0) begin
                            mode_next = MODE_IDLE;
                        end else begin
                            mode_next       = MODE_GAP;
                            tick_timer_next = gap_length_reg;
                        end
                    end
                end
                MODE_GAP: begin
                    tick_timer_next = timer_dec;
                    if (timer_dec == '0) begin
                        // Gap over: next beep at the held volume.
                        beeps_left_next = beeps_left_reg - COUNT_W'(1);
                        mode_next       = MODE_BEEPING;
                        tick_timer_next = beep_length_reg;
                        level_next      = held_volume_reg;
                    end
                end
                default: begin
                    // Tick while idle forces silence.
                    level_next = SILENCE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beep_length_reg <= BEEP_LENGTH_RST;
            gap_length_reg  <= GAP_LENGTH_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_BEEP_LENGTH: beep_length_reg <= cfg_data;
                CFG_GAP_LENGTH:  gap_length_reg  <= cfg_data;
                default: begin
                    // Unknown index: drop the write.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            tick_timer_reg  <= '0;
            beeps_left_reg  <= '0;
            held_volume_reg <= '0;
            level_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (s_accept) begin
                mode_reg        <= mode_next;
                tick_timer_reg  <= tick_timer_next;
                beeps_left_reg  <= beeps_left_next;
                held_volume_reg <= held_volume_next;
                level_reg       <= level_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/bbs_checker.sv
`default_nettype none

module bbs_checker (
    input wire                         aclk,
    input wire                         aresetn,
    input wire                         s_valid,
    input wire                         s_ready,
    input wire                         s_cmd,
    input wire [bbs_pkg::COUNT_W-1:0]  s_beep_count,
    input wire [bbs_pkg::LEVEL_W-1:0]  s_volume,
    input wire                         m_valid,
    input wire                         m_ready,
    input wire [bbs_pkg::LEVEL_W-1:0]  m_drive_level,
    input wire                         m_busy_res
);
    import bbs_pkg::*;

    // A stalled result holds.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_level) && $stable(m_busy_res))
        else $error("result changed while stalled");

    // Every item transfer yields a result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result after item transfer");

    // Idle always reads as silent.
    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res |-> m_drive_level == SILENCE)
        else $error("drive level nonzero while idle");

    // An audible request starts a beep at its volume.
    a_request_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_cmd == CMD_REQUEST) && (s_beep_count != '0)
            && (s_volume != '0)
        |=> m_busy_res && (m_drive_level == $past(s_volume)))
        else $error("request did not start a beep");

endmodule

bind beep_burst_sequencer_top bbs_checker u_bbs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_cmd         (s_cmd),
    .s_beep_count  (s_beep_count),
    .s_volume      (s_volume),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_drive_level (m_drive_level),
    .m_busy_res    (m_busy_res)
);

`default_nettype wire

>>> verif/beep_burst_sequencer_top_test.sv
module beep_burst_sequencer_top_test;
    import bbs_pkg::*;

    // One result per transfer: drive level and busy flag after the item.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               busy;
    } beeper_out_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    wire                    s_ready;
    logic                   s_cmd = CMD_TICK;
    logic [COUNT_W-1:0]     s_beep_count = '0;
    logic [LEVEL_W-1:0]     s_volume = '0;
    wire                    m_valid;
    logic                   m_ready = 1'b0;
    wire  [LEVEL_W-1:0]     m_drive_level;
    wire                    m_busy_res;
    logic                   cfg_valid = 1'b0;
    wire                    cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_BEEP_LENGTH;
    logic [TIMER_W-1:0]     cfg_data = '0;

    // Predicted sequencer state and lengths, mirrored from reset values.
    logic [TIMER_W-1:0] beep_len_m = BEEP_LENGTH_RST;
    logic [TIMER_W-1:0] gap_len_m = GAP_LENGTH_RST;
    logic [TIMER_W-1:0] timer_m = '0;
    logic [COUNT_W-1:0] beeps_left_m = '0;
    logic [LEVEL_W-1:0] volume_m = '0;
    logic [LEVEL_W-1:0] level_m = SILENCE;
    mode_t              mode_m = MODE_IDLE;

    // Expected drive level / busy pairs, oldest first.
    beeper_out_t drive_q[$];
    int          errors = 0;
    bit          idle_en = 1'b1;
    int          stall_left = 0;

    beep_burst_sequencer_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_beep_count  (s_beep_count),
        .s_volume      (s_volume),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive_level (m_drive_level),
        .m_busy_res    (m_busy_res),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Consume one beep and sound the held volume for a full beep length.
    function void start_beep_m();
        beeps_left_m = beeps_left_m - 1'b1;
        mode_m = MODE_BEEPING;
        timer_m = beep_len_m;
        level_m = volume_m;
    endfunction

    // Advance the predicted sequencer by one accepted item and return its result.
    function automatic beeper_out_t advance_beeper(input logic cmd,
                                                   input logic [COUNT_W-1:0] count,
                                                   input logic [LEVEL_W-1:0] vol);
        beeper_out_t res;
        if (cmd == CMD_REQUEST) begin
            // Zero count drops the request; zero volume only reloads the count.
            if (count != '0) begin
                beeps_left_m = count;
                if (vol != '0) begin
                    volume_m = vol;
                    start_beep_m();
                end
            end
        end else if (mode_m == MODE_BEEPING) begin
            // Decrement before the zero test, so a length of 0 runs 256 ticks.
            timer_m = timer_m - 1'b1;
            if (timer_m == '0) begin
                level_m = SILENCE;
                if (beeps_left_m == '0) begin
                    mode_m = MODE_IDLE;
                end else begin
                    mode_m = MODE_GAP;
                    timer_m = gap_len_m;
                end
            end
        end else if (mode_m == MODE_GAP) begin
            timer_m = timer_m - 1'b1;
            if (timer_m == '0) begin
                start_beep_m();
            end
        end else begin
            // Tick while idle: force silence.
            level_m = SILENCE;
        end
        res.level = level_m;
        res.busy = (mode_m == MODE_BEEPING) || (mode_m == MODE_GAP);
        return res;
    endfunction

    // Result side: stall m_ready in random bursts while idling is enabled.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left = stall_left - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            m_ready = 1'b0;
            stall_left = $urandom_range(0, 12);
        end else begin
            m_ready = 1'b1;
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge aclk) begin : check_output
        beeper_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (drive_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual level %0d busy %0b",
                         $time, m_drive_level, m_busy_res);
                errors = errors + 1;
            end else begin
                want = drive_q.pop_front();
                if (m_drive_level !== want.level) begin
                    $display("%0t: drive_level mismatch, expected %0d, actual %0d",
                             $time, want.level, m_drive_level);
                    errors = errors + 1;
                end
                if (m_busy_res !== want.busy) begin
                    $display("%0t: busy_res mismatch, expected %0b, actual %0b",
                             $time, want.busy, m_busy_res);
                    errors = errors + 1;
                end
            end
        end
    end

    // Send one item, with an optional random hold-off first; leave valid high
    // after the transfer so back-to-back items can follow at once.
    task automatic issue_event(input logic cmd, input logic [COUNT_W-1:0] count,
                               input logic [LEVEL_W-1:0] vol);
        int gap;
        @(negedge aclk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_cmd = cmd;
        s_beep_count = count;
        s_volume = vol;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        drive_q.push_back(advance_beeper(cmd, count, vol));
    endtask

    // Tick with random don't-care request fields.
    task automatic tick();
        issue_event(CMD_TICK, COUNT_W'($urandom), LEVEL_W'($urandom));
    endtask

    // Drop valid and hold until every predicted result has been taken.
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (drive_q.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Write both length registers once every predicted result has been taken.
    task automatic set_lengths(input logic [TIMER_W-1:0] beep_len,
                               input logic [TIMER_W-1:0] gap_len);
        settle();
        for (int i = 0; i < 2; i++) begin
            @(negedge aclk);
            cfg_index = (i == 0) ? CFG_BEEP_LENGTH : CFG_GAP_LENGTH;
            cfg_data = (i == 0) ? beep_len : gap_len;
            cfg_valid = 1'b1;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            if (i == 0) begin
                beep_len_m = beep_len;
            end else begin
                gap_len_m = gap_len;
            end
        end
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Mostly ticks with occasional requests; small counts let bursts run to
    // their end, while zero counts, zero volumes and full-range counts mix in.
    task automatic random_events(input int n);
        logic               cmd;
        logic [COUNT_W-1:0] count;
        logic [LEVEL_W-1:0] vol;
        for (int k = 0; k < n; k++) begin
            // Now and then hold the sender until the result side runs dry.
            if ($urandom_range(0, 99) == 0) begin
                settle();
            end
            cmd = ($urandom_range(0, 8) == 0) ? CMD_REQUEST : CMD_TICK;
            case ($urandom_range(0, 9))
                0: count = '0;
                1, 2: count = COUNT_W'($urandom);
                default: count = COUNT_W'($urandom_range(1, 4));
            endcase
            vol = ($urandom_range(0, 6) == 0) ? '0 : LEVEL_W'($urandom_range(1, 255));
            issue_event(cmd, count, vol);
        end
    endtask

    // Reset lengths: a two-beep burst runs beep, gap, beep and drops to idle.
    task automatic test_reset_lengths();
        issue_event(CMD_REQUEST, 8'd2, LEVEL_W'($urandom_range(1, 255)));
        repeat (151) tick();
    endtask

    // Short lengths so every transition shows up in a handful of items.
    task automatic test_special_cases();
        set_lengths(8'd2, 8'd1);
        tick();                                   // idle tick stays silent
        issue_event(CMD_REQUEST, 8'd0, 8'hFF);    // zero count: ignored
        issue_event(CMD_REQUEST, 8'd3, 8'd0);     // zero volume: count only
        tick();
        issue_event(CMD_REQUEST, 8'd2, 8'hFF);    // start a beep at full level
        issue_event(CMD_REQUEST, 8'd5, 8'd0);     // reload count while beeping
        tick();
        tick();                                   // beep ends, enter the gap
        tick();                                   // gap ends, next beep
        issue_event(CMD_REQUEST, 8'd1, 8'd1);     // restart while beeping
        tick();
        tick();                                   // last beep ends, go idle
        tick();
        issue_event(CMD_REQUEST, 8'hFF, 8'h80);   // full count
        tick();
        tick();                                   // now in a gap
        issue_event(CMD_REQUEST, 8'd1, 8'h55);    // restart from the gap
        tick();
        tick();
        tick();
    endtask

    // A zero length wraps the 8-bit timer: the phase lasts 256 ticks.
    task automatic test_zero_length();
        set_lengths(8'd0, 8'd1);
        issue_event(CMD_REQUEST, 8'd2, 8'd77);
        repeat (256 + 1 + 256 + 1) tick();
        set_lengths(8'd1, 8'd0);
        issue_event(CMD_REQUEST, 8'd2, 8'd200);
        repeat (1 + 256 + 1 + 1) tick();
    endtask

    // Random traffic over the length extremes and a few random settings.
    task automatic test_random_settings();
        set_lengths(8'd1, 8'd1);
        random_events(100);
        set_lengths(8'd255, 8'd255);
        random_events(50);
        set_lengths(8'd255, 8'd1);
        random_events(50);
        set_lengths(8'd1, 8'd255);
        random_events(50);
        repeat (3) begin
            set_lengths(TIMER_W'($urandom_range(1, 12)), TIMER_W'($urandom_range(1, 12)));
            random_events(100);
        end
    endtask

    // Full rate on both sides to finish.
    task automatic test_no_idling();
        set_lengths(8'd3, 8'd2);
        idle_en = 1'b0;
        stall_left = 0;
        random_events(120);
    endtask

    initial begin
        // Hold reset low, then release it on a falling edge.
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_lengths();
        test_special_cases();
        test_zero_length();
        test_random_settings();
        test_no_idling();

        // Drain the result side, then let the pipeline run out.
        settle();
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
